// ----- sv/mgr_pkg.sv -----
// shared types, codes and reset constants for the mute gain ramp unit
`default_nettype none

package mgr_pkg;

    localparam int SAMPLE_BITS_DEFAULT = 24;
    localparam int COUNT_BITS_DEFAULT  = 12;

    localparam int DOWN_LENGTH_RESET = 64;
    localparam int UP_LENGTH_RESET   = 256;
    localparam int DEAD_LENGTH_RESET = 0;

    localparam int OP_BITS  = 2;
    localparam int CFG_BITS = 2;

    localparam logic [OP_BITS-1:0] OP_SAMPLE   = 2'd0;
    localparam logic [OP_BITS-1:0] OP_FADE_IN  = 2'd1;
    localparam logic [OP_BITS-1:0] OP_FADE_OUT = 2'd2;

    localparam logic [CFG_BITS-1:0] CFG_DOWN_LENGTH = 2'd0;
    localparam logic [CFG_BITS-1:0] CFG_UP_LENGTH   = 2'd1;
    localparam logic [CFG_BITS-1:0] CFG_DEAD_LENGTH = 2'd2;
    localparam logic [CFG_BITS-1:0] CFG_HALTED      = 2'd3;

    typedef enum logic [2:0] {
        MODE_DOWN_DEAD = 3'd0,
        MODE_UP_DEAD   = 3'd1,
        MODE_UP        = 3'd2,
        MODE_DOWN      = 3'd3,
        MODE_OFF       = 3'd4
    } t_mode;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_OUT
    } t_state;

endpackage

`default_nettype wire

// ----- sv/mgr_div.sv -----
// serial restoring divider, one quotient bit per cycle
`default_nettype none

module mgr_div
    import mgr_pkg::*;
#(
    parameter int DIVIDEND_BITS = SAMPLE_BITS_DEFAULT + COUNT_BITS_DEFAULT,
    parameter int DIVISOR_BITS  = COUNT_BITS_DEFAULT
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_start,
    input  wire logic [DIVIDEND_BITS-1:0] i_dividend,
    input  wire logic [DIVISOR_BITS-1:0]  i_divisor,
    output logic                          o_done,
    output logic [DIVIDEND_BITS-1:0]      o_quotient
);

    localparam int CNT_BITS = $clog2(DIVIDEND_BITS + 1);

    logic                     r_busy;
    logic                     r_done;
    logic [CNT_BITS-1:0]      r_cnt;
    logic [DIVIDEND_BITS-1:0] r_quo;
    logic [DIVISOR_BITS-1:0]  r_rem;
    logic [DIVISOR_BITS-1:0]  r_div;

    logic [DIVISOR_BITS:0]    shifted;
    logic                     fits;
    logic [DIVISOR_BITS:0]    diff;

    assign shifted = {r_rem, r_quo[DIVIDEND_BITS-1]};
    assign fits    = shifted >= {1'b0, r_div};
    assign diff    = shifted - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_BITS'(1);
                if (r_cnt == CNT_BITS'(DIVIDEND_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIVIDEND_BITS-2:0], fits};
            r_rem <= fits ? diff[DIVISOR_BITS-1:0] : shifted[DIVISOR_BITS-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

// ----- sv/mute_gain_ramp_unit.sv -----
// top level of the mute gain ramp unit: ramp control, scaling sequencer and stream ports
//
// De-click fader on a signed audio sample stream. Sample items are muted, held
// silent, faded in, faded out or passed according to the ramp mode; fade-in and
// fade-out command items arm the ramp and give no result. A sample that must be
// scaled passes through a multiply state and then the serial divider, one quotient
// bit per cycle, that forms trunc(sample * count / length). Other sample items
// skip both and go straight to the output state; command items leave the input
// open. The output register lets the next item in while a result waits to be
// taken.
`default_nettype none

module mute_gain_ramp_unit
    import mgr_pkg::*;
#(
    parameter  int SAMPLE_BITS = SAMPLE_BITS_DEFAULT,
    parameter  int COUNT_BITS  = COUNT_BITS_DEFAULT,
    localparam int IN_BITS     = ((SAMPLE_BITS + 7) / 8) * 8,
    localparam int OUT_BITS    = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_tvalid,
    output logic                       o_s_tready,
    input  wire logic [IN_BITS-1:0]    i_s_tdata,   // sample_in
    input  wire logic [OP_BITS-1:0]    i_s_tuser,   // opcode
    input  wire logic                  i_s_tlast,
    output logic                       o_m_tvalid,
    input  wire logic                  i_m_tready,
    output logic [OUT_BITS-1:0]        o_m_tdata,   // sample_out
    output logic                       o_m_tlast,
    output logic [2:0]                 o_m_tuser,   // mode_out
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_BITS-1:0]   i_cfg_index,
    input  wire logic [COUNT_BITS-1:0] i_cfg_data
);

    localparam int PROD_BITS = SAMPLE_BITS + COUNT_BITS;
    localparam logic [PROD_BITS-1:0] NEG_LIMIT = PROD_BITS'(1) << (SAMPLE_BITS - 1);
    localparam logic [PROD_BITS-1:0] POS_LIMIT = NEG_LIMIT - PROD_BITS'(1);

    t_state                 r_state, n_state;
    t_mode                  r_mode;
    logic [COUNT_BITS-1:0]  r_count;
    logic [COUNT_BITS-1:0]  r_down_len;
    logic [COUNT_BITS-1:0]  r_up_len;
    logic [COUNT_BITS-1:0]  r_dead_len;
    logic                   r_halted;

    logic [SAMPLE_BITS-1:0] r_res_sample;
    logic                   r_res_last;
    logic                   r_neg;
    logic [SAMPLE_BITS-1:0] r_mag;
    logic [COUNT_BITS-1:0]  r_num;
    logic [COUNT_BITS-1:0]  r_den;

    logic                   r_out_valid;
    logic [SAMPLE_BITS-1:0] r_out_sample;
    logic                   r_out_last;
    t_mode                  r_out_mode;

    logic [OP_BITS-1:0]     in_op;
    logic [SAMPLE_BITS-1:0] in_sample;
    logic                   in_accept;
    logic                   out_free;
    logic                   out_load;
    logic                   div_start;
    logic                   div_done;
    logic [PROD_BITS-1:0]   div_quo;
    logic [PROD_BITS-1:0]   product;
    logic [SAMPLE_BITS-1:0] sat_sample;

    t_mode                  d_mode;
    logic [COUNT_BITS-1:0]  d_count;
    logic                   d_result;
    logic                   d_scale;
    logic [SAMPLE_BITS-1:0] d_direct;
    logic [COUNT_BITS-1:0]  d_num;
    logic [COUNT_BITS-1:0]  d_den;

    assign in_op     = i_s_tuser;
    assign in_sample = i_s_tdata[SAMPLE_BITS-1:0];
    assign in_accept = i_s_tvalid && o_s_tready;
    assign out_free  = !r_out_valid || i_m_tready;

    // item decode: ramp mode and count update, scaling request
    always_comb begin
        logic [COUNT_BITS-1:0] clamp;
        logic [COUNT_BITS:0]   dead_next;
        logic [COUNT_BITS:0]   up_next;
        clamp     = (r_count < r_down_len) ? r_count : r_down_len;
        dead_next = {1'b0, r_count} + (COUNT_BITS+1)'(1);
        up_next   = '0;
        d_mode    = r_mode;
        d_count   = r_count;
        d_result  = 1'b0;
        d_scale   = 1'b0;
        d_direct  = '0;
        d_num     = r_count;
        d_den     = r_up_len;
        case (in_op)
            OP_FADE_IN: begin
                if (!r_halted) begin
                    d_mode  = MODE_UP_DEAD;
                    d_count = '0;
                end
            end
            OP_FADE_OUT: begin
                if (r_mode != MODE_DOWN_DEAD && r_mode != MODE_DOWN) begin
                    if (clamp == '0) begin
                        d_mode = MODE_DOWN_DEAD;
                    end else begin
                        d_mode  = MODE_DOWN;
                        d_count = clamp;
                    end
                end
            end
            OP_SAMPLE: begin
                d_result = 1'b1;
                if (r_mode == MODE_UP_DEAD) begin
                    if (dead_next > {1'b0, r_dead_len}) begin
                        d_mode  = MODE_UP;
                        d_count = '0;
                    end else begin
                        d_count = dead_next[COUNT_BITS-1:0];
                    end
                end
                up_next = {1'b0, d_count} + (COUNT_BITS+1)'(1);
                if (d_mode == MODE_UP) begin
                    d_count = up_next[COUNT_BITS-1:0];
                    if (up_next >= {1'b0, r_up_len}) begin
                        d_mode   = MODE_OFF;
                        d_direct = in_sample;
                    end else begin
                        d_scale = 1'b1;
                        d_num   = up_next[COUNT_BITS-1:0];
                        d_den   = r_up_len;
                    end
                end else if (d_mode == MODE_DOWN) begin
                    if (d_count <= COUNT_BITS'(1)) begin
                        d_count = '0;
                        d_mode  = MODE_DOWN_DEAD;
                    end else begin
                        d_count = d_count - COUNT_BITS'(1);
                        d_num   = d_count;
                        d_den   = r_down_len;
                        d_scale = r_down_len != '0;
                    end
                end else if (d_mode == MODE_OFF) begin
                    d_direct = in_sample;
                end
            end
            default: ;
        endcase
    end

    // sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_accept && d_result) begin
                    n_state = d_scale ? ST_MUL : ST_OUT;
                end
            end
            ST_MUL: n_state = ST_DIV;
            ST_DIV: begin
                if (div_done) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        o_s_tready = 1'b0;
        div_start  = 1'b0;
        out_load   = 1'b0;
        case (r_state)
            ST_IDLE: o_s_tready = i_rst_n;
            ST_MUL:  div_start  = 1'b1;
            ST_OUT:  out_load   = out_free;
            default: ;
        endcase
    end

    assign product = {{COUNT_BITS{1'b0}}, r_mag} * {{SAMPLE_BITS{1'b0}}, r_num};

    mgr_div #(
        .DIVIDEND_BITS (PROD_BITS),
        .DIVISOR_BITS  (COUNT_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (product),
        .i_divisor  (r_den),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    always_comb begin
        if (r_neg) begin
            sat_sample = (div_quo > NEG_LIMIT) ? NEG_LIMIT[SAMPLE_BITS-1:0]
                                               : -div_quo[SAMPLE_BITS-1:0];
        end else begin
            sat_sample = (div_quo > POS_LIMIT) ? POS_LIMIT[SAMPLE_BITS-1:0]
                                               : div_quo[SAMPLE_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_mode      <= MODE_DOWN_DEAD;
            r_count     <= '0;
            r_down_len  <= COUNT_BITS'(DOWN_LENGTH_RESET);
            r_up_len    <= COUNT_BITS'(UP_LENGTH_RESET);
            r_dead_len  <= COUNT_BITS'(DEAD_LENGTH_RESET);
            r_halted    <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_accept) begin
                r_mode  <= d_mode;
                r_count <= d_count;
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_DOWN_LENGTH: r_down_len <= i_cfg_data;
                    CFG_UP_LENGTH:   r_up_len   <= i_cfg_data;
                    CFG_DEAD_LENGTH: r_dead_len <= i_cfg_data;
                    CFG_HALTED:      r_halted   <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept && d_result) begin
            r_res_sample <= d_direct;
            r_res_last   <= i_s_tlast;
            r_neg        <= in_sample[SAMPLE_BITS-1];
            r_mag        <= in_sample[SAMPLE_BITS-1] ? (~in_sample + SAMPLE_BITS'(1)) : in_sample;
            r_num        <= d_num;
            r_den        <= d_den;
        end else if (r_state == ST_DIV && div_done) begin
            r_res_sample <= sat_sample;
        end
        if (out_load) begin
            r_out_sample <= r_res_sample;
            r_out_last   <= r_res_last;
            r_out_mode   <= r_mode;
        end
    end

    assign o_cfg_ready = i_rst_n;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = OUT_BITS'(r_out_sample);
    assign o_m_tlast   = r_out_last;
    assign o_m_tuser   = r_out_mode;

endmodule

`default_nettype wire

// ----- sv/mgr_checker.sv -----
// port-level assertions for the mute gain ramp unit, bound to the top level
`default_nettype none

module mgr_checker
    import mgr_pkg::*;
#(
    parameter  int SAMPLE_BITS = SAMPLE_BITS_DEFAULT,
    parameter  int COUNT_BITS  = COUNT_BITS_DEFAULT,
    localparam int OUT_BITS    = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  i_s_tvalid,
    input wire logic                  o_s_tready,
    input wire logic [OP_BITS-1:0]    i_s_tuser,
    input wire logic                  o_m_tvalid,
    input wire logic                  i_m_tready,
    input wire logic [OUT_BITS-1:0]   o_m_tdata,
    input wire logic [2:0]            o_m_tuser
);

    // no item leaves right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid right after reset");

    // a stalled item stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("result dropped while stalled");

    // muted and dead modes give silence
    a_mute_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser == MODE_DOWN_DEAD || o_m_tuser == MODE_UP_DEAD)
        |-> o_m_tdata[SAMPLE_BITS-1:0] == '0)
        else $error("nonzero sample while muted");

    // a sample item keeps the input closed for the next cycle
    a_busy_after_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && i_s_tuser == OP_SAMPLE |=> !o_s_tready)
        else $error("input open while a sample is in work");

endmodule

bind mute_gain_ramp_unit mgr_checker #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COUNT_BITS  (COUNT_BITS)
) u_mgr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_s_tvalid  (i_s_tvalid),
    .o_s_tready  (o_s_tready),
    .i_s_tuser   (i_s_tuser),
    .o_m_tvalid  (o_m_tvalid),
    .i_m_tready  (i_m_tready),
    .o_m_tdata   (o_m_tdata),
    .o_m_tuser   (o_m_tuser)
);

`default_nettype wire
